[hdl/scc_pkg.sv]
// Shared constants and types for the script chunk splitter.
package scc_pkg;

  // Character codes the scanner reacts to
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChLbr   = 8'h7B;
  localparam logic [7:0] ChRbr   = 8'h7D;
  localparam logic [7:0] ChBtk   = 8'h60;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  localparam logic [31:0] LineMax = 32'hFFFF_FFFF;

  // Default nesting limit for slash-star comments
  localparam int unsigned MaxCommentDepthDef = 255;

  // Scanner mode, one-hot
  typedef enum logic [2:0] {
    ModeNormal  = 3'b001,
    ModeQuote   = 3'b010,
    ModeComment = 3'b100
  } scan_mode_e;

  // True for space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

endpackage

[hdl/script_chunk_splitter_top.sv]
// Script chunk splitter: per-byte scanner with input and result registers.
//
//  channel | signals                                         | dir
//  --------+-------------------------------------------------+-----
//  in      | in_valid_i, in_stall_o, text_byte_i             | in
//  out     | out_valid_o, out_stall_i, out_byte_o, keep_o,   | out
//          | chunk_end_o, chunk_has_text_o, line_number_o    |
//
// One byte per clock sustained while the output is not stalled; a byte passes the
// input register, then the result register. A request lands in the input register, and the scanner state and result
// register update together when the result register is free or drained.
// Reset puts the scanner in normal mode with line count one, both stages empty.
// A stalled result holds; the input register keeps accepting while it can pass
// its byte on, and stalls only when both stages are full.
module script_chunk_splitter_top #(
  parameter int unsigned MAX_COMMENT_DEPTH = scc_pkg::MaxCommentDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        keep_o,
  output logic        chunk_end_o,
  output logic        chunk_has_text_o,
  output logic [31:0] line_number_o
);
  import scc_pkg::*;

  localparam int unsigned DepthW = $clog2(MAX_COMMENT_DEPTH + 1);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_COMMENT_DEPTH);
  localparam logic [DepthW-1:0] DepthOne = DepthW'(1);

  // Pipeline control
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic       adv;

  // Scanner state
  scan_mode_e       mode_q, mode_d;
  logic [7:0]       normal_prev_q, normal_prev_d;
  logic             in_block_q, in_block_d;
  logic [7:0]       quote_char_q, quote_char_d;
  logic [7:0]       inner_prev_q, inner_prev_d;
  logic [DepthW-1:0] depth_q, depth_d, depth_t;
  logic [31:0]      line_q, line_d;
  logic             seen_q, seen_d;

  // Result values
  logic res_keep, res_end, res_has;

  // Move the input byte on when the result register is empty or draining
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !adv;

  // Scan one byte
  always_comb begin
    mode_d        = mode_q;
    normal_prev_d = normal_prev_q;
    in_block_d    = in_block_q;
    quote_char_d  = quote_char_q;
    inner_prev_d  = inner_prev_q;
    depth_d       = depth_q;
    depth_t       = depth_q;
    line_d        = line_q;
    seen_d        = seen_q;
    res_keep      = 1'b1;
    res_end       = 1'b0;

    if (in_byte_q == ChCr) begin
      res_keep = 1'b0;
    end else begin
      if (in_byte_q == ChLf && line_q != LineMax) begin
        line_d = line_q + 32'd1;
      end
      if (!is_space(in_byte_q)) begin
        seen_d = 1'b1;
      end

      case (mode_q)
        ModeQuote: begin
          if (in_byte_q == quote_char_q && inner_prev_q != ChBsl) begin
            mode_d = ModeNormal;
          end else begin
            inner_prev_d = in_byte_q;
          end
        end
        ModeComment: begin
          // Close or open one nesting level, saturating both ways
          if (inner_prev_q == ChStar && in_byte_q == ChSlash && depth_q != '0) begin
            depth_t = depth_q - DepthOne;
          end
          if (inner_prev_q == ChSlash && in_byte_q == ChStar && depth_q < DepthMax) begin
            depth_t = depth_q + DepthOne;
          end
          depth_d = depth_t;
          if (depth_t == '0) begin
            mode_d = ModeNormal;
          end else begin
            inner_prev_d = in_byte_q;
          end
        end
        default: begin
          if (normal_prev_q == ChSlash && in_byte_q == ChStar) begin
            mode_d       = ModeComment;
            depth_d      = DepthOne;
            inner_prev_d = '0;
          end else if (in_byte_q == ChSq || in_byte_q == ChDq || in_byte_q == ChBtk) begin
            mode_d       = ModeQuote;
            quote_char_d = in_byte_q;
            inner_prev_d = in_byte_q;
          end else if (!in_block_q && normal_prev_q == ChLf && in_byte_q == ChLf) begin
            res_end = 1'b1;
          end else begin
            if (normal_prev_q == ChLbr) begin
              in_block_d = 1'b1;
            end
            if (normal_prev_q == ChLf && in_byte_q == ChRbr) begin
              in_block_d = 1'b0;
            end
            normal_prev_d = in_byte_q;
          end
        end
      endcase
    end

    res_has = seen_d;

    // Start a fresh chunk after the closing newline
    if (res_end) begin
      normal_prev_d = '0;
      in_block_d    = 1'b0;
      seen_d        = 1'b0;
      mode_d        = ModeNormal;
    end
  end

  // Control registers and scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      mode_q        <= ModeNormal;
      normal_prev_q <= '0;
      in_block_q    <= 1'b0;
      quote_char_q  <= '0;
      inner_prev_q  <= '0;
      depth_q       <= '0;
      line_q        <= 32'd1;
      seen_q        <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv && in_valid_q) begin
        mode_q        <= mode_d;
        normal_prev_q <= normal_prev_d;
        in_block_q    <= in_block_d;
        quote_char_q  <= quote_char_d;
        inner_prev_q  <= inner_prev_d;
        depth_q       <= depth_d;
        line_q        <= line_d;
        seen_q        <= seen_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= text_byte_i;
    end
    if (adv && in_valid_q) begin
      out_byte_o       <= in_byte_q;
      keep_o           <= res_keep;
      chunk_end_o      <= res_end;
      chunk_has_text_o <= res_has;
      line_number_o    <= line_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
